[rtl/fcc_pkg.sv]
package fcc_pkg;

    localparam int ADDR_W   = 12;
    localparam int TEXEL_W  = 24;
    localparam int COLOR_W  = 23;
    localparam int COORD_W  = 11;
    localparam int DIST_W   = 24;
    localparam int MAG_W    = 20;
    localparam int PROD_W   = DIST_W + MAG_W;
    localparam int DVD_W    = 28;
    localparam int DVS_W    = 11;
    localparam int CNT_W    = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ROW   = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;

    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;
    localparam logic [2:0] REG_WIDTH   = 3'd6;
    localparam logic [2:0] REG_HEIGHT  = 3'd7;

    localparam logic [23:0] RST_POS_X   = 24'd131072;
    localparam logic [23:0] RST_POS_Y   = 24'd131072;
    localparam logic [18:0] RST_DIR_X   = 19'h70000;
    localparam logic [18:0] RST_DIR_Y   = 19'd0;
    localparam logic [18:0] RST_PLANE_X = 19'd0;
    localparam logic [18:0] RST_PLANE_Y = 19'd43254;
    localparam logic [10:0] RST_WIDTH   = 11'd640;
    localparam logic [10:0] RST_HEIGHT  = 11'd480;

    localparam logic [COLOR_W-1:0] RGB_HALF_MASK = 23'h7F7F7F;
    localparam logic [DIST_W-1:0]  DIST_MAX      = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]          op;
        logic                which_texture;
        logic [ADDR_W-1:0]   texel_index;
        logic [TEXEL_W-1:0]  texel_value;
        logic [COORD_W-1:0]  row;
    } in_word_t;

    typedef struct packed {
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  floor_row;
        logic [COORD_W-1:0]  ceiling_row;
        logic [COLOR_W-1:0]  floor_color;
        logic [COLOR_W-1:0]  ceiling_color;
        logic                last_in_row;
    } out_word_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_ROW,
        CMD_PIXEL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                which_texture;
        logic [ADDR_W-1:0]   texel_index;
        logic [TEXEL_W-1:0]  texel_value;
        logic [COORD_W-1:0]  row;
    } cmd_t;

    typedef struct packed {
        logic [23:0]         pos_x;
        logic [23:0]         pos_y;
        logic signed [18:0]  dir_x;
        logic signed [18:0]  dir_y;
        logic signed [18:0]  plane_x;
        logic signed [18:0]  plane_y;
        logic [10:0]         width;
        logic [10:0]         height;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic row_done;
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_MUL_SX,
        ST_DIV_SX,
        ST_WAIT_SX,
        ST_MUL_SY,
        ST_DIV_SY,
        ST_WAIT_SY,
        ST_MUL_WX,
        ST_ADD_WX,
        ST_MUL_WY,
        ST_ADD_WY,
        ST_ADDR,
        ST_PIX
    } back_state_t;

endpackage

[rtl/fcc_ram.sv]
module fcc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/fcc_div.sv]
module fcc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fcc_pkg::DVD_W-1:0]  dividend,
    input  logic [fcc_pkg::DVS_W-1:0]  divisor,
    output logic                       done,
    output logic [fcc_pkg::DVD_W-1:0]  quotient
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [fcc_pkg::CNT_W-1:0]  cnt_reg;
    logic [fcc_pkg::DVS_W-1:0]  rem_reg;
    logic [fcc_pkg::DVD_W-1:0]  quo_reg;
    logic [fcc_pkg::DVS_W-1:0]  dvs_reg;
    logic [fcc_pkg::DVS_W:0]    rem_shift;
    logic [fcc_pkg::DVS_W:0]    rem_diff;
    logic                       ge;

    // one quotient bit a cycle, restoring
    assign rem_shift = {rem_reg, quo_reg[fcc_pkg::DVD_W-1]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= fcc_pkg::CNT_W'(fcc_pkg::DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == fcc_pkg::CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_diff[fcc_pkg::DVS_W-1:0] : rem_shift[fcc_pkg::DVS_W-1:0];
            quo_reg <= {quo_reg[fcc_pkg::DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/fcc_front.sv]
module fcc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fcc_pkg::in_word_t   in_word,
    output logic                cmd_valid,
    output fcc_pkg::cmd_t       cmd,
    input  logic                cmd_pop
);

    localparam int PTR_W = $clog2(fcc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(fcc_pkg::QUEUE_DEPTH + 1);

    fcc_pkg::cmd_t      entry_reg [fcc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    fcc_pkg::cmd_t      decoded;
    logic               known_op;
    logic               accept;
    logic               push;
    logic               pop;

    // classify the op; an unused code is taken and dropped here
    always_comb
    begin
        decoded.which_texture = in_word.which_texture;
        decoded.texel_index   = in_word.texel_index;
        decoded.texel_value   = in_word.texel_value;
        decoded.row           = in_word.row;
        known_op              = 1'b1;
        case (in_word.op)
            fcc_pkg::OP_LOAD:  decoded.kind = fcc_pkg::CMD_LOAD;
            fcc_pkg::OP_ROW:   decoded.kind = fcc_pkg::CMD_ROW;
            fcc_pkg::OP_PIXEL: decoded.kind = fcc_pkg::CMD_PIXEL;
            default:
            begin
                decoded.kind = fcc_pkg::CMD_LOAD;
                known_op     = 1'b0;
            end
        endcase
    end

    assign in_stall  = count_reg == CNT_W'(fcc_pkg::QUEUE_DEPTH);
    assign accept    = in_valid && !in_stall;
    assign push      = accept && known_op;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_valid = count_reg != '0;
    assign cmd       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

[rtl/fcc_back.sv]
module fcc_back #(
    parameter int TEX_WIDTH  = 64,
    parameter int TEX_HEIGHT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  fcc_pkg::cmd_t       cmd,
    output logic                cmd_pop,
    input  fcc_pkg::cfg_t       cfg,
    output logic                out_valid,
    input  logic                out_stall,
    output fcc_pkg::out_word_t  out_word,
    output fcc_pkg::status_t    status
);

    localparam int TWB = $clog2(TEX_WIDTH + 1);
    localparam int THB = $clog2(TEX_HEIGHT + 1);
    localparam int AFW = TWB + THB + fcc_pkg::ADDR_W;
    localparam int AW  = fcc_pkg::ADDR_W;
    localparam int CW  = fcc_pkg::COORD_W;

    fcc_pkg::back_state_t state_reg, state_next;

    logic [31:0]                 world_x_reg, world_y_reg, step_x_reg, step_y_reg;
    logic [CW-1:0]               column_reg, cur_row_reg, row_reg;
    logic [fcc_pkg::DIST_W-1:0]  dist_reg;
    logic [fcc_pkg::PROD_W-1:0]  prod_reg;
    logic                        neg_reg;
    logic [TWB-1:0]              tx_reg;
    logic [THB-1:0]              ty_reg;
    logic                        out_valid_reg;
    fcc_pkg::out_word_t          out_word_reg;

    logic                        div_start, div_done;
    logic [fcc_pkg::DVD_W-1:0]   div_dvd, div_q;
    logic [fcc_pkg::DVS_W-1:0]   div_dvs;
    logic [fcc_pkg::MAG_W-1:0]   mul_b;
    logic                        mul_neg;
    logic                        mul_load;
    logic                        ram_we, ram_re;
    logic [fcc_pkg::TEXEL_W-1:0] floor_texel, ceil_texel;

    logic [CW-1:0]               half, p;
    logic signed [19:0]          px2, py2, dmx, dmy;
    logic [16+TWB-1:0]           tx_prod;
    logic [16+THB-1:0]           ty_prod;
    logic [AFW-1:0]              addr_full;
    logic [31:0]                 scaled, scaled_q, signed_prod, signed_q;
    logic                        row_done, out_free;

    function automatic logic [fcc_pkg::MAG_W-1:0] mag20(input logic signed [19:0] v);
        mag20 = v[19] ? fcc_pkg::MAG_W'(-v) : fcc_pkg::MAG_W'(v);
    endfunction

    assign half    = cfg.height >> 1;
    assign p       = (cmd.row > half) ? cmd.row - half : CW'(1);
    assign px2     = {cfg.plane_x, 1'b0};
    assign py2     = {cfg.plane_y, 1'b0};
    assign dmx     = 20'(cfg.dir_x) - 20'(cfg.plane_x);
    assign dmy     = 20'(cfg.dir_y) - 20'(cfg.plane_y);
    // row distance from idle, column steps from the scaled product
    assign div_dvd = (state_reg == fcc_pkg::ST_IDLE) ? fcc_pkg::DVD_W'({cfg.height, 15'b0})
                                                     : prod_reg[fcc_pkg::PROD_W-1:16];

    // texel coordinates from the fraction bits
    assign tx_prod   = {{TWB{1'b0}}, world_x_reg[15:0]} * (16+TWB)'(TEX_WIDTH);
    assign ty_prod   = {{THB{1'b0}}, world_y_reg[15:0]} * (16+THB)'(TEX_HEIGHT);
    assign addr_full = AFW'(TEX_WIDTH) * AFW'(ty_reg) + AFW'(tx_reg);

    assign scaled      = {4'b0, prod_reg[fcc_pkg::PROD_W-1:16]};
    assign scaled_q    = {4'b0, div_q};
    assign signed_prod = neg_reg ? 32'(-scaled) : scaled;
    assign signed_q    = neg_reg ? 32'(-scaled_q) : scaled_q;

    assign row_done = {1'b0, column_reg} >= {1'b0, cfg.width};
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        div_start  = 1'b0;
        div_dvs    = p;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        mul_b      = '0;
        mul_neg    = 1'b0;
        mul_load   = 1'b0;
        case (state_reg)
            fcc_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        fcc_pkg::CMD_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        fcc_pkg::CMD_ROW:
                        begin
                            div_start  = 1'b1;
                            state_next = fcc_pkg::ST_DIST;
                        end
                        fcc_pkg::CMD_PIXEL:
                        begin
                            if (!row_done)
                            begin
                                state_next = fcc_pkg::ST_ADDR;
                            end
                        end
                        default:
                        begin
                            state_next = fcc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            fcc_pkg::ST_DIST:
            begin
                if (div_done)
                begin
                    state_next = fcc_pkg::ST_MUL_SX;
                end
            end
            fcc_pkg::ST_MUL_SX:
            begin
                mul_b      = mag20(px2);
                mul_neg    = px2[19];
                mul_load   = 1'b1;
                state_next = fcc_pkg::ST_DIV_SX;
            end
            fcc_pkg::ST_DIV_SX:
            begin
                div_start  = 1'b1;
                div_dvs    = (cfg.width == '0) ? CW'(1) : cfg.width;
                state_next = fcc_pkg::ST_WAIT_SX;
            end
            fcc_pkg::ST_WAIT_SX:
            begin
                if (div_done)
                begin
                    state_next = fcc_pkg::ST_MUL_SY;
                end
            end
            fcc_pkg::ST_MUL_SY:
            begin
                mul_b      = mag20(py2);
                mul_neg    = py2[19];
                mul_load   = 1'b1;
                state_next = fcc_pkg::ST_DIV_SY;
            end
            fcc_pkg::ST_DIV_SY:
            begin
                div_start  = 1'b1;
                div_dvs    = (cfg.width == '0) ? CW'(1) : cfg.width;
                state_next = fcc_pkg::ST_WAIT_SY;
            end
            fcc_pkg::ST_WAIT_SY:
            begin
                if (div_done)
                begin
                    state_next = fcc_pkg::ST_MUL_WX;
                end
            end
            fcc_pkg::ST_MUL_WX:
            begin
                mul_b      = mag20(dmx);
                mul_neg    = dmx[19];
                mul_load   = 1'b1;
                state_next = fcc_pkg::ST_ADD_WX;
            end
            fcc_pkg::ST_ADD_WX:
            begin
                state_next = fcc_pkg::ST_MUL_WY;
            end
            fcc_pkg::ST_MUL_WY:
            begin
                mul_b      = mag20(dmy);
                mul_neg    = dmy[19];
                mul_load   = 1'b1;
                state_next = fcc_pkg::ST_ADD_WY;
            end
            fcc_pkg::ST_ADD_WY:
            begin
                state_next = fcc_pkg::ST_IDLE;
            end
            fcc_pkg::ST_ADDR:
            begin
                ram_re     = 1'b1;
                state_next = fcc_pkg::ST_PIX;
            end
            fcc_pkg::ST_PIX:
            begin
                if (out_free)
                begin
                    state_next = fcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_x_reg   <= '0;
            world_y_reg   <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            column_reg    <= fcc_pkg::RST_WIDTH;
            cur_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == fcc_pkg::ST_PIX && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                fcc_pkg::ST_WAIT_SX:
                begin
                    if (div_done)
                    begin
                        step_x_reg <= signed_q;
                    end
                end
                fcc_pkg::ST_WAIT_SY:
                begin
                    if (div_done)
                    begin
                        step_y_reg <= signed_q;
                    end
                end
                fcc_pkg::ST_ADD_WX:
                begin
                    world_x_reg <= {8'b0, cfg.pos_x} + signed_prod;
                end
                fcc_pkg::ST_ADD_WY:
                begin
                    world_y_reg <= {8'b0, cfg.pos_y} + signed_prod;
                    cur_row_reg <= row_reg;
                    column_reg  <= '0;
                end
                fcc_pkg::ST_PIX:
                begin
                    if (out_free)
                    begin
                        world_x_reg   <= world_x_reg + step_x_reg;
                        world_y_reg   <= world_y_reg + step_y_reg;
                        column_reg    <= column_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        // product and sign held until the next multiply
        if (mul_load)
        begin
            prod_reg <= dist_reg * mul_b;
            neg_reg  <= mul_neg;
        end
        tx_reg   <= tx_prod[16 +: TWB];
        ty_reg   <= ty_prod[16 +: THB];
        if (state_reg == fcc_pkg::ST_IDLE && cmd_valid && cmd.kind == fcc_pkg::CMD_ROW)
        begin
            row_reg <= cmd.row;
        end
        if (state_reg == fcc_pkg::ST_DIST && div_done)
        begin
            dist_reg <= (div_q > fcc_pkg::DVD_W'(fcc_pkg::DIST_MAX))
                      ? fcc_pkg::DIST_MAX : div_q[fcc_pkg::DIST_W-1:0];
        end
        if (state_reg == fcc_pkg::ST_PIX && out_free)
        begin
            out_word_reg.column        <= column_reg;
            out_word_reg.floor_row     <= cur_row_reg;
            out_word_reg.ceiling_row   <= cfg.height - cur_row_reg - 1'b1;
            out_word_reg.floor_color   <= floor_texel[23:1] & fcc_pkg::RGB_HALF_MASK;
            out_word_reg.ceiling_color <= ceil_texel[23:1] & fcc_pkg::RGB_HALF_MASK;
            out_word_reg.last_in_row   <= ({1'b0, column_reg} + 1'b1) >= {1'b0, cfg.width};
        end
    end

    fcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    fcc_ram #(.WIDTH(fcc_pkg::TEXEL_W), .DEPTH(1 << AW)) u_floor_ram (
        .clk   (clk),
        .we    (ram_we && !cmd.which_texture),
        .waddr (cmd.texel_index),
        .wdata (cmd.texel_value),
        .re    (ram_re),
        .raddr (addr_full[AW-1:0]),
        .rdata (floor_texel)
    );

    fcc_ram #(.WIDTH(fcc_pkg::TEXEL_W), .DEPTH(1 << AW)) u_ceil_ram (
        .clk   (clk),
        .we    (ram_we && cmd.which_texture),
        .waddr (cmd.texel_index),
        .wdata (cmd.texel_value),
        .re    (ram_re),
        .raddr (addr_full[AW-1:0]),
        .rdata (ceil_texel)
    );

    assign out_valid       = out_valid_reg;
    assign out_word        = out_word_reg;
    assign status.busy     = state_reg != fcc_pkg::ST_IDLE;
    assign status.row_done = row_done;

endmodule

[rtl/floor_ceiling_texture_caster_top.sv]
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | in_word  (op, texture, index, texel, row)
// out     | output    | out_valid/out_stall | out_word (column, rows, colors, last)
// cfg     | apb       | psel/penable/pready | paddr, pwdata, prdata (8 registers)
//
// a load word writes the texture store as it is popped, a next-pixel word passes
// through queue pop, texel address and a registered texture read
// a start-row word makes three passes through the shared radix-2 divider (distance,
// then both column steps), each giving a 28-bit quotient, plus issue, multiplies and adds
// a two-word queue between decoder and executor, so in_stall rises only when full
// out_word sits in an output register; the executor holds a pixel while it is stalled
// reset: registers to defaults, row marked done, queue and output empty
module floor_ceiling_texture_caster_top #(
    parameter int TEX_WIDTH  = 64,
    parameter int TEX_HEIGHT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fcc_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output fcc_pkg::out_word_t  out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // configuration registers
    fcc_pkg::cfg_t      cfg_reg;
    logic               cfg_write;
    logic [2:0]         reg_index;

    // queue between decoder and executor
    logic               cmd_valid;
    logic               cmd_pop;
    fcc_pkg::cmd_t      cmd;
    fcc_pkg::status_t   status;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x   <= fcc_pkg::RST_POS_X;
            cfg_reg.pos_y   <= fcc_pkg::RST_POS_Y;
            cfg_reg.dir_x   <= fcc_pkg::RST_DIR_X;
            cfg_reg.dir_y   <= fcc_pkg::RST_DIR_Y;
            cfg_reg.plane_x <= fcc_pkg::RST_PLANE_X;
            cfg_reg.plane_y <= fcc_pkg::RST_PLANE_Y;
            cfg_reg.width   <= fcc_pkg::RST_WIDTH;
            cfg_reg.height  <= fcc_pkg::RST_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                fcc_pkg::REG_POS_X:   cfg_reg.pos_x   <= pwdata[23:0];
                fcc_pkg::REG_POS_Y:   cfg_reg.pos_y   <= pwdata[23:0];
                fcc_pkg::REG_DIR_X:   cfg_reg.dir_x   <= pwdata[18:0];
                fcc_pkg::REG_DIR_Y:   cfg_reg.dir_y   <= pwdata[18:0];
                fcc_pkg::REG_PLANE_X: cfg_reg.plane_x <= pwdata[18:0];
                fcc_pkg::REG_PLANE_Y: cfg_reg.plane_y <= pwdata[18:0];
                fcc_pkg::REG_WIDTH:   cfg_reg.width   <= pwdata[10:0];
                fcc_pkg::REG_HEIGHT:  cfg_reg.height  <= pwdata[10:0];
                default:              cfg_reg.height  <= cfg_reg.height;
            endcase
        end
    end

    // register readback, zero extended
    always_comb
    begin
        case (reg_index)
            fcc_pkg::REG_POS_X:   prdata = {8'b0, cfg_reg.pos_x};
            fcc_pkg::REG_POS_Y:   prdata = {8'b0, cfg_reg.pos_y};
            fcc_pkg::REG_DIR_X:   prdata = {13'b0, cfg_reg.dir_x};
            fcc_pkg::REG_DIR_Y:   prdata = {13'b0, cfg_reg.dir_y};
            fcc_pkg::REG_PLANE_X: prdata = {13'b0, cfg_reg.plane_x};
            fcc_pkg::REG_PLANE_Y: prdata = {13'b0, cfg_reg.plane_y};
            fcc_pkg::REG_WIDTH:   prdata = {21'b0, cfg_reg.width};
            fcc_pkg::REG_HEIGHT:  prdata = {21'b0, cfg_reg.height};
            default:              prdata = '0;
        endcase
    end

    // decoder and queue
    fcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // row setup, texture store and pixel walk
    fcc_back #(
        .TEX_WIDTH  (TEX_WIDTH),
        .TEX_HEIGHT (TEX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .status    (status)
    );

    // a pending pixel that is not the last one leaves the row open
    a_row_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.last_in_row |-> !status.row_done)
        else $error("row done with a pixel still to come");

    // a stalled pixel word holds still
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled pixel word changed");

    // a pending pixel lies inside the screen
    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.column < cfg_reg.width)
        else $error("column beyond screen width");

    // halved colors keep the top bit of each channel clear
    a_shade_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_word.floor_color & ~fcc_pkg::RGB_HALF_MASK) == '0)
            && ((out_word.ceiling_color & ~fcc_pkg::RGB_HALF_MASK) == '0))
        else $error("shaded color outside mask");

endmodule

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEX_W      = 64;
    localparam int TEX_H      = 64;
    localparam int TEX_WORDS  = 4096;
    localparam logic [1:0] OP_SPARE = 2'd3;   // unused op code, ignored by the block
    localparam int SETTLE     = 200;          // covers a start-row word in flight
    localparam int HOLD_LEN   = 400;
    localparam int BATCH      = 180;          // words per random batch

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    fcc_pkg::in_word_t   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    fcc_pkg::out_word_t  out_word;
    logic       psel = 1'b0;
    logic       penable = 1'b0;
    logic       pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic       pready;

    floor_ceiling_texture_caster_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // predictor copy of the camera registers
    logic [23:0]        cam_pos_x, cam_pos_y;
    logic signed [18:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
    logic [10:0]        scr_width, scr_height;

    // predictor copy of the caster state
    logic [23:0] texels [2][TEX_WORDS];
    bit          texel_set [2][TEX_WORDS];
    logic [31:0] walk_x, walk_y, stride_x, stride_y;
    logic [10:0] col_pos, row_now;

    fcc_pkg::in_word_t  words_to_send [$];
    fcc_pkg::out_word_t pixels_due [$];

    int  errors = 0;
    int  pixels_seen = 0;
    int  words_sent = 0;
    int  words_queued = 0;
    int  rows_started = 0;
    bit  calm = 1'b0;       // no idling on either side
    bit  hold_req = 1'b0;   // ask the receiver for a long hold-off
    bit  in_fire = 1'b0;

    task automatic report_miss(input string what, input longint got, input longint want);
        $display("mismatch %0s: got %0h want %0h (pixel %0d)", what, got, want, pixels_seen);
        errors++;
    endtask

    // sign(s) * ((row_dist * |s| / dv) >> 16), 32 bit wrap
    function automatic logic [31:0] scale_by(input logic [31:0] row_dist, input longint s,
                                             input longint unsigned dv);
        longint unsigned mag, q;
        logic [31:0] r;
        mag = (s < 0) ? longint'(-s) : longint'(s);
        q = ((longint'(row_dist) * mag) / dv) >> 16;
        r = q[31:0];
        return (s < 0) ? -r : r;
    endfunction

    function automatic void begin_row(input logic [10:0] r);
        logic [10:0] half, offs;
        longint unsigned d, dv;
        logic [31:0] row_dist;
        half = scr_height >> 1;
        offs = (r > half) ? r - half : 11'd1;
        d = (longint'(scr_height) << 15) / offs;
        row_dist = (d > 64'hFFFFFF) ? 32'hFFFFFF : d[31:0];
        dv = (scr_width != 0) ? longint'(scr_width) : longint'(1);
        stride_x = scale_by(row_dist, 2 * longint'(cam_plane_x), dv);
        stride_y = scale_by(row_dist, 2 * longint'(cam_plane_y), dv);
        walk_x = {8'd0, cam_pos_x}
               + scale_by(row_dist, longint'(cam_dir_x) - longint'(cam_plane_x), 1);
        walk_y = {8'd0, cam_pos_y}
               + scale_by(row_dist, longint'(cam_dir_y) - longint'(cam_plane_y), 1);
        row_now = r;
        col_pos = '0;
    endfunction

    function automatic logic [11:0] texel_addr();
        longint unsigned tx, ty;
        tx = (longint'(walk_x[15:0]) * TEX_W) >> 16;
        ty = (longint'(walk_y[15:0]) * TEX_H) >> 16;
        return 12'((TEX_W * ty + tx) % TEX_WORDS);
    endfunction

    function automatic fcc_pkg::in_word_t noise_word(input logic [1:0] op);
        fcc_pkg::in_word_t w;
        w.op = op;
        w.which_texture = 1'($urandom);
        w.texel_index = 12'($urandom);
        w.texel_value = 24'($urandom);
        w.row = 11'($urandom);
        return w;
    endfunction

    task automatic push_word(input fcc_pkg::in_word_t w);
        words_to_send.push_back(w);
        words_queued++;
    endtask

    task automatic send_load(input bit tex, input logic [11:0] idx, input logic [23:0] val);
        fcc_pkg::in_word_t w;
        w = noise_word(fcc_pkg::OP_LOAD);
        w.which_texture = tex;
        w.texel_index = idx;
        w.texel_value = val;
        texels[tex][idx] = val;
        texel_set[tex][idx] = 1'b1;
        push_word(w);
    endtask

    task automatic send_row(input logic [10:0] r);
        fcc_pkg::in_word_t w;
        w = noise_word(fcc_pkg::OP_ROW);
        w.row = r;
        begin_row(r);
        rows_started++;
        push_word(w);
    endtask

    // preloads any texel the pixel would read that was never written
    task automatic send_pixel();
        logic [11:0] a;
        fcc_pkg::out_word_t p;
        if (col_pos < scr_width)
        begin
            a = texel_addr();
            if (!texel_set[0][a])
                send_load(1'b0, a, 24'($urandom));
            if (!texel_set[1][a])
                send_load(1'b1, a, 24'($urandom));
            p.column = col_pos;
            p.floor_row = row_now;
            p.ceiling_row = scr_height - row_now - 11'd1;
            p.floor_color = 23'(texels[0][a] >> 1) & fcc_pkg::RGB_HALF_MASK;
            p.ceiling_color = 23'(texels[1][a] >> 1) & fcc_pkg::RGB_HALF_MASK;
            p.last_in_row = (32'(col_pos) + 1 >= 32'(scr_width));
            pixels_due.push_back(p);
            walk_x += stride_x;
            walk_y += stride_y;
            col_pos++;
        end
        push_word(noise_word(fcc_pkg::OP_PIXEL));
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            fcc_pkg::REG_POS_X:   cam_pos_x = val[23:0];
            fcc_pkg::REG_POS_Y:   cam_pos_y = val[23:0];
            fcc_pkg::REG_DIR_X:   cam_dir_x = val[18:0];
            fcc_pkg::REG_DIR_Y:   cam_dir_y = val[18:0];
            fcc_pkg::REG_PLANE_X: cam_plane_x = val[18:0];
            fcc_pkg::REG_PLANE_Y: cam_plane_y = val[18:0];
            fcc_pkg::REG_WIDTH:   scr_width = val[10:0];
            default:              scr_height = val[10:0];
        endcase
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_camera(input logic [23:0] px, input logic [23:0] py,
                              input int dx, input int dy, input int qx, input int qy,
                              input logic [10:0] w, input logic [10:0] h);
        reg_write(fcc_pkg::REG_POS_X, 32'(px));
        reg_write(fcc_pkg::REG_POS_Y, 32'(py));
        reg_write(fcc_pkg::REG_DIR_X, 32'(dx));
        reg_write(fcc_pkg::REG_DIR_Y, 32'(dy));
        reg_write(fcc_pkg::REG_PLANE_X, 32'(qx));
        reg_write(fcc_pkg::REG_PLANE_Y, 32'(qy));
        reg_write(fcc_pkg::REG_WIDTH, 32'(w));
        reg_write(fcc_pkg::REG_HEIGHT, 32'(h));
    endtask

    // wait until every word went in and every pixel came out, then let the block settle
    task automatic drain();
        while (words_to_send.size() != 0 || in_valid || pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // rows with a run of pixels, sprinkled with loads and noise
    task automatic random_rows(input int n);
        int start, run;
        start = words_queued;
        while (words_queued - start < n)
        begin
            case ($urandom_range(9))
                0: send_load(1'($urandom), 12'($urandom), 24'($urandom));
                1: push_word(noise_word(OP_SPARE));
                2: send_pixel();
                default:
                begin
                    if ($urandom_range(1))
                        send_row(11'(scr_height / 2 + $urandom_range(scr_height / 2 + 2)));
                    else
                        send_row(11'($urandom));
                    run = $urandom_range(1, 24);
                    if (scr_width < 24 && $urandom_range(1))
                        run = int'(scr_width) + int'($urandom_range(2));
                    repeat (run) send_pixel();
                end
            endcase
        end
    endtask

    // driver: words change on the falling edge
    always @(posedge clk)
        in_fire <= in_valid && !in_stall;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (words_to_send.size() != 0 && (calm || $urandom_range(99) >= 31))
                begin
                    in_word <= words_to_send.pop_front();
                    in_valid <= 1'b1;
                    words_sent++;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off counted here
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 31);
        end
    end

    // monitor: compare each pixel word with the oldest prediction
    always @(posedge clk)
    begin
        fcc_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixels_due.size() == 0)
            begin
                report_miss("unexpected pixel, column", longint'(out_word.column), longint'(0));
            end
            else
            begin
                want = pixels_due.pop_front();
                if (out_word.column !== want.column)
                    report_miss("column", longint'(out_word.column), longint'(want.column));
                if (out_word.floor_row !== want.floor_row)
                    report_miss("floor_row", longint'(out_word.floor_row),
                                longint'(want.floor_row));
                if (out_word.ceiling_row !== want.ceiling_row)
                    report_miss("ceiling_row", longint'(out_word.ceiling_row),
                                longint'(want.ceiling_row));
                if (out_word.floor_color !== want.floor_color)
                    report_miss("floor_color", longint'(out_word.floor_color),
                                longint'(want.floor_color));
                if (out_word.ceiling_color !== want.ceiling_color)
                    report_miss("ceiling_color", longint'(out_word.ceiling_color),
                                longint'(want.ceiling_color));
                if (out_word.last_in_row !== want.last_in_row)
                    report_miss("last_in_row", longint'(out_word.last_in_row),
                                longint'(want.last_in_row));
            end
            pixels_seen++;
        end
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d pixels outstanding", pixels_due.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        cam_pos_x = fcc_pkg::RST_POS_X;
        cam_pos_y = fcc_pkg::RST_POS_Y;
        cam_dir_x = fcc_pkg::RST_DIR_X;
        cam_dir_y = fcc_pkg::RST_DIR_Y;
        cam_plane_x = fcc_pkg::RST_PLANE_X;
        cam_plane_y = fcc_pkg::RST_PLANE_Y;
        scr_width = fcc_pkg::RST_WIDTH;
        scr_height = fcc_pkg::RST_HEIGHT;
        walk_x = '0;
        walk_y = '0;
        stride_x = '0;
        stride_y = '0;
        col_pos = fcc_pkg::RST_WIDTH;    // row done after reset
        row_now = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, row done, extremes of the fields
        send_pixel();                                   // row done, no pixel
        push_word(noise_word(OP_SPARE));
        send_load(1'b0, 12'h000, 24'h000000);
        send_load(1'b1, 12'hFFF, 24'hFFFFFF);
        send_load(1'b0, 12'hFFF, 24'hFFFFFF);
        send_load(1'b1, 12'h000, 24'h000000);
        send_row(11'd0);                                // above the horizon
        repeat (3) send_pixel();
        send_row(11'd240);                              // on the horizon
        send_pixel();
        send_row(11'd2047);
        repeat (3) send_pixel();
        send_row(11'd241);
        repeat (4) send_pixel();
        drain();

        // small screen so rows end, and pixels past the end give nothing
        set_camera(24'h000000, 24'hFFFFFF, 131072, -131072, -131072, 131072, 11'd3, 11'd2);
        send_row(11'd1);
        repeat (5) send_pixel();
        send_row(11'd2047);
        repeat (4) send_pixel();
        drain();

        // width changed after a finished row: the next row ends at the new width
        reg_write(fcc_pkg::REG_WIDTH, 32'd1);
        send_pixel();
        send_row(11'd5);
        repeat (2) send_pixel();
        drain();

        // receiver holds off while words keep coming
        set_camera(24'hFFFFFF, 24'h000000, -131072, 131072, 131072, -131072, 11'd2047, 11'd2047);
        hold_req = 1'b1;
        random_rows(BATCH);
        drain();

        set_camera(fcc_pkg::RST_POS_X, fcc_pkg::RST_POS_Y, -65536, 0, 0, 43254,
                   11'd640, 11'd480);
        random_rows(BATCH);
        drain();

        // tiny screen, many complete rows
        set_camera(24'($urandom), 24'($urandom), $urandom_range(262144) - 131072,
                   $urandom_range(262144) - 131072, $urandom_range(262144) - 131072,
                   $urandom_range(262144) - 131072, 11'($urandom_range(1, 6)),
                   11'($urandom_range(2, 12)));
        random_rows(BATCH);
        drain();

        // stretch with no idling on either side
        calm = 1'b1;
        set_camera(24'($urandom), 24'($urandom), $urandom_range(262144) - 131072,
                   $urandom_range(262144) - 131072, $urandom_range(262144) - 131072,
                   $urandom_range(262144) - 131072, 11'($urandom_range(1, 2047)),
                   11'($urandom_range(2, 2047)));
        random_rows(BATCH);
        drain();
        calm = 1'b0;

        set_camera(24'($urandom), 24'($urandom), $urandom_range(262144) - 131072,
                   $urandom_range(262144) - 131072, $urandom_range(262144) - 131072,
                   $urandom_range(262144) - 131072, 11'($urandom_range(1, 64)),
                   11'($urandom_range(2, 2047)));
        random_rows(BATCH);
        drain();

        $display("sent %0d words, started %0d rows, checked %0d pixels", words_sent,
                 rows_started, pixels_seen);
        $display("camera settings covered register extremes, long receiver hold-off");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
